### rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants for the differential-drive odometry
// Field types, register indexes and reset values, CORDIC constants.
// ----------------------------------------------------------------------------
package ddo_pkg;

    typedef logic signed [15:0] step_rate_t;   // steps per second
    typedef logic signed [31:0] fix_t;         // Q16.16
    typedef logic        [31:0] bam_t;         // binary angle, 2^32 = 2 pi
    typedef logic        [1:0]  cfg_index_t;
    typedef logic        [27:0] cfg_data_t;    // widest register

    // register indexes
    localparam cfg_index_t CFG_DISTANCE_PER_STEP  = 2'd0;
    localparam cfg_index_t CFG_TICK_PERIOD        = 2'd1;
    localparam cfg_index_t CFG_INVERSE_WHEEL_BASE = 2'd2;

    // register reset values
    localparam logic [27:0] DPS_RESET = 28'd6746518;
    localparam logic [23:0] TP_RESET  = 24'd16777;
    localparam logic [23:0] IWB_RESET = 24'd262144;

    // CORDIC start vector, 0.60725293 * 2^30
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    // round(2^32 / (2 pi))
    localparam logic [29:0] RAD_TO_BAM = 30'd683565276;

    // atan(2^-i) as binary angle
    localparam logic [29:0] ATAN_TABLE [32] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81,
        30'd41,        30'd20,        30'd10,        30'd5,
        30'd3,         30'd1,         30'd1,         30'd0
    };

endpackage

### rtl/ddo_in_if.sv
// ----------------------------------------------------------------------------
// ddo_in_if: tick channel
// One word per update tick: left and right wheel step rates.
// ----------------------------------------------------------------------------
interface ddo_in_if;
    import ddo_pkg::*;

    logic       valid;
    logic       ready;
    step_rate_t left_step_rate;
    step_rate_t right_step_rate;

    modport source (output valid, output left_step_rate, output right_step_rate,
                    input ready);
    modport sink   (input valid, input left_step_rate, input right_step_rate,
                    output ready);
endinterface

### rtl/ddo_out_if.sv
// ----------------------------------------------------------------------------
// ddo_out_if: result channel
// One word per tick: pose, heading, linear and angular velocity.
// ----------------------------------------------------------------------------
interface ddo_out_if;
    import ddo_pkg::*;

    logic valid;
    logic ready;
    fix_t pose_x;
    fix_t pose_y;
    bam_t heading;
    fix_t linear_velocity;
    fix_t angular_velocity;

    modport source (output valid, output pose_x, output pose_y, output heading,
                    output linear_velocity, output angular_velocity,
                    input ready);
    modport sink   (input valid, input pose_x, input pose_y, input heading,
                    input linear_velocity, input angular_velocity,
                    output ready);
endinterface

### rtl/differential_drive_odometry.sv
// A tick is taken only in idle; the block is busy until its result is committed, and a
// commit waits while an unread result is held. The sequence is set by the shared 64x9
// multiply-accumulate (25 digit steps per tick) and the CORDIC rotation, one iteration
// per cycle.
// Reset (rst_n, async, active low): pose and heading to zero, registers to defaults.
// ----------------------------------------------------------------------------
// differential_drive_odometry: fixed-point dead reckoning for a two-wheel base
// Wheel speeds, pose integration along the old heading, heading advance.
// ----------------------------------------------------------------------------
module differential_drive_odometry #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    ddo_in_if.sink               tick,
    ddo_out_if.source            result,
    input  logic                 cfg_we,
    input  ddo_pkg::cfg_index_t  cfg_index,
    input  ddo_pkg::cfg_data_t   cfg_data
);
    import ddo_pkg::*;

    localparam int IT_W  = $clog2(CORDIC_ITERATIONS);
    localparam int ACC_W = 96;   // holds every product mod 2^96

    // Sequencer. Each MUL state runs one product through the shared
    // multiply-accumulate, one 8-bit digit of the B operand per cycle.
    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_MSL   = 12'b0000_0000_0010,  // left speed  = rate_l * dps
        ST_MSR   = 12'b0000_0000_0100,  // right speed = rate_r * dps
        ST_PREP  = 12'b0000_0000_1000,  // speed sum/diff, CORDIC setup
        ST_MANG  = 12'b0000_0001_0000,  // diff * inverse wheel base
        ST_MDIST = 12'b0000_0010_0000,  // sum * tick period
        ST_ROT   = 12'b0000_0100_0000,  // CORDIC iterations
        ST_MDX   = 12'b0000_1000_0000,  // dist * cos
        ST_MDY   = 12'b0001_0000_0000,  // dist * sin
        ST_MAT   = 12'b0010_0000_0000,  // angular rate * tick period
        ST_MTH   = 12'b0100_0000_0000,  // * rad-to-bam
        ST_UPD   = 12'b1000_0000_0000   // commit pose, load result
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [27:0] dps_reg;
    logic [23:0] tp_reg;
    logic [23:0] iwb_reg;

    // architectural state
    fix_t pos_x_reg, pos_y_reg;
    bam_t heading_reg;

    // per-tick working registers
    step_rate_t               left_reg, right_reg;
    logic signed [27:0]       sl_reg, sr_reg;
    logic signed [28:0]       wsum_reg, wdiff_reg;
    logic signed [36:0]       ang_reg;
    logic signed [52:0]       dist_reg;
    logic signed [60:0]       at_reg;
    logic signed [31:0]       dx_reg, dy_reg;
    logic        [31:0]       dth_reg;

    // multiply-accumulate
    logic [1:0]               dig_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [63:0]       a_op;
    logic        [32:0]       b_op;
    logic [1:0]               ndig_m1;
    logic signed [8:0]        digit;
    logic signed [72:0]       prod;
    logic signed [ACC_W-1:0]  addend;
    logic                     is_mul, dig_last;

    // CORDIC
    logic [IT_W-1:0]          rot_cnt_reg;
    logic signed [33:0]       cx_reg, cy_reg, cz_reg;
    logic                     flip_reg;
    logic signed [33:0]       xs, ys, atan_v, nx, ny, nz;
    logic                     rot_last;
    logic [31:0]              turn_q, start_angle;

    // result register
    logic out_valid_reg;
    fix_t out_x_reg, out_y_reg, out_lin_reg, out_ang_reg;
    bam_t out_hdg_reg;

    logic        commit;
    logic [32:0] px_sum, py_sum;
    fix_t        px_sat, py_sat, ang_sat;

    assign tick.ready = (state_reg == ST_IDLE);

    assign result.valid            = out_valid_reg;
    assign result.pose_x           = out_x_reg;
    assign result.pose_y           = out_y_reg;
    assign result.heading          = out_hdg_reg;
    assign result.linear_velocity  = out_lin_reg;
    assign result.angular_velocity = out_ang_reg;

    // ---------------- operand select for the shared multiplier ----------------
    always_comb
    begin
        a_op    = '0;
        b_op    = '0;
        ndig_m1 = 2'd0;
        case (state_reg)
            ST_MSL:
            begin
                a_op    = {36'd0, dps_reg};
                b_op    = {{17{left_reg[15]}}, left_reg};
                ndig_m1 = 2'd1;
            end
            ST_MSR:
            begin
                a_op    = {36'd0, dps_reg};
                b_op    = {{17{right_reg[15]}}, right_reg};
                ndig_m1 = 2'd1;
            end
            ST_MANG:
            begin
                a_op    = {{35{wdiff_reg[28]}}, wdiff_reg};
                b_op    = {9'd0, iwb_reg};
                ndig_m1 = 2'd2;
            end
            ST_MDIST:
            begin
                a_op    = {{35{wsum_reg[28]}}, wsum_reg};
                b_op    = {9'd0, tp_reg};
                ndig_m1 = 2'd2;
            end
            ST_MDX:
            begin
                a_op    = {{11{dist_reg[52]}}, dist_reg};
                b_op    = cx_reg[32:0];   // |cos| < 2^31
                ndig_m1 = 2'd3;
            end
            ST_MDY:
            begin
                a_op    = {{11{dist_reg[52]}}, dist_reg};
                b_op    = cy_reg[32:0];
                ndig_m1 = 2'd3;
            end
            ST_MAT:
            begin
                a_op    = {{27{ang_reg[36]}}, ang_reg};
                b_op    = {9'd0, tp_reg};
                ndig_m1 = 2'd2;
            end
            ST_MTH:
            begin
                a_op    = {{3{at_reg[60]}}, at_reg};
                b_op    = {3'd0, RAD_TO_BAM};
                ndig_m1 = 2'd3;
            end
            default:
            begin
                a_op    = '0;
                b_op    = '0;
                ndig_m1 = 2'd0;
            end
        endcase
    end

    assign is_mul   = state_reg inside {ST_MSL, ST_MSR, ST_MANG, ST_MDIST,
                                        ST_MDX, ST_MDY, ST_MAT, ST_MTH};
    assign dig_last = (dig_reg == ndig_m1);

    // Lower digits are unsigned; the top digit carries the sign of B.
    assign digit  = dig_last ? $signed(b_op[{dig_reg, 3'b000} +: 9])
                             : $signed({1'b0, b_op[{dig_reg, 3'b000} +: 8]});
    assign prod   = a_op * digit;
    assign addend = {{(ACC_W-73){prod[72]}}, prod} <<< {dig_reg, 3'b000};
    assign acc_next = ((dig_reg == 2'd0) ? '0 : acc_reg) + addend;

    // ---------------- CORDIC step ----------------
    // Turn by 180 degrees when outside +-90, negate at the end.
    assign turn_q      = heading_reg + 32'h4000_0000;
    assign start_angle = turn_q[31] ? (heading_reg ^ 32'h8000_0000) : heading_reg;

    assign xs     = cx_reg >>> rot_cnt_reg;
    assign ys     = cy_reg >>> rot_cnt_reg;
    assign atan_v = $signed({4'd0, ATAN_TABLE[5'(rot_cnt_reg)]});
    assign rot_last = (rot_cnt_reg == IT_W'(CORDIC_ITERATIONS - 1));

    always_comb
    begin
        if (!cz_reg[33])
        begin
            nx = cx_reg - ys;
            ny = cy_reg + xs;
            nz = cz_reg - atan_v;
        end
        else
        begin
            nx = cx_reg + ys;
            ny = cy_reg - xs;
            nz = cz_reg + atan_v;
        end
    end

    // ---------------- commit: saturating pose, heading wrap ----------------
    assign commit = (state_reg == ST_UPD) && (!out_valid_reg || result.ready);

    assign px_sum = {pos_x_reg[31], pos_x_reg} + {dx_reg[31], dx_reg};
    assign py_sum = {pos_y_reg[31], pos_y_reg} + {dy_reg[31], dy_reg};
    assign px_sat = (px_sum[32] != px_sum[31])
                  ? (px_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : px_sum[31:0];
    assign py_sat = (py_sum[32] != py_sum[31])
                  ? (py_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : py_sum[31:0];
    assign ang_sat = ((ang_reg[36:31] == 6'b000000) || (ang_reg[36:31] == 6'b111111))
                   ? ang_reg[31:0]
                   : (ang_reg[36] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (tick.valid) state_next = ST_MSL;
            ST_MSL:   if (dig_last) state_next = ST_MSR;
            ST_MSR:   if (dig_last) state_next = ST_PREP;
            ST_PREP:  state_next = ST_MANG;
            ST_MANG:  if (dig_last) state_next = ST_MDIST;
            ST_MDIST: if (dig_last) state_next = ST_ROT;
            ST_ROT:   if (rot_last) state_next = ST_MDX;
            ST_MDX:   if (dig_last) state_next = ST_MDY;
            ST_MDY:   if (dig_last) state_next = ST_MAT;
            ST_MAT:   if (dig_last) state_next = ST_MTH;
            ST_MTH:   if (dig_last) state_next = ST_UPD;
            ST_UPD:   if (commit) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dig_reg       <= 2'd0;
            rot_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (is_mul)
                dig_reg <= dig_last ? 2'd0 : dig_reg + 2'd1;
            if (state_reg == ST_PREP)
                rot_cnt_reg <= '0;
            else if (state_reg == ST_ROT)
                rot_cnt_reg <= rot_cnt_reg + 1'b1;
            if (commit)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dps_reg <= DPS_RESET;
            tp_reg  <= TP_RESET;
            iwb_reg <= IWB_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DISTANCE_PER_STEP:  dps_reg <= cfg_data;
                CFG_TICK_PERIOD:        tp_reg  <= cfg_data[23:0];
                CFG_INVERSE_WHEEL_BASE: iwb_reg <= cfg_data[23:0];
                default: ;   // unknown index: ignored
            endcase
        end
    end

    // pose and heading
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            heading_reg <= '0;
        end
        else if (commit)
        begin
            pos_x_reg   <= px_sat;
            pos_y_reg   <= py_sat;
            heading_reg <= heading_reg + dth_reg;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            left_reg  <= tick.left_step_rate;
            right_reg <= tick.right_step_rate;
        end

        if (is_mul)
            acc_reg <= acc_next;

        // capture each product on its last digit, floor shift by slicing
        if (is_mul && dig_last)
        begin
            case (state_reg)
                ST_MSL:   sl_reg   <= acc_next[43:16];
                ST_MSR:   sr_reg   <= acc_next[43:16];
                ST_MANG:  ang_reg  <= acc_next[52:16];
                ST_MDIST: dist_reg <= acc_next[52:0];
                ST_MDX:   dx_reg   <= acc_next[86:55];
                ST_MDY:   dy_reg   <= acc_next[86:55];
                ST_MAT:   at_reg   <= acc_next[60:0];
                ST_MTH:   dth_reg  <= acc_next[71:40];
                default: ;
            endcase
        end

        if (state_reg == ST_PREP)
        begin
            wsum_reg  <= {sl_reg[27], sl_reg} + {sr_reg[27], sr_reg};
            wdiff_reg <= {sr_reg[27], sr_reg} - {sl_reg[27], sl_reg};
            cx_reg    <= CORDIC_START;
            cy_reg    <= '0;
            cz_reg    <= {{2{start_angle[31]}}, start_angle};
            flip_reg  <= turn_q[31];
        end
        else if (state_reg == ST_ROT)
        begin
            cz_reg <= nz;
            if (rot_last && flip_reg)
            begin
                cx_reg <= -nx;
                cy_reg <= -ny;
            end
            else
            begin
                cx_reg <= nx;
                cy_reg <= ny;
            end
        end

        if (commit)
        begin
            out_x_reg   <= px_sat;
            out_y_reg   <= py_sat;
            out_hdg_reg <= heading_reg + dth_reg;
            out_lin_reg <= {{4{wsum_reg[28]}}, wsum_reg[28:1]};
            out_ang_reg <= ang_sat;
        end
    end

`ifndef SYNTHESIS
    // an accepted word always starts the left-speed product
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (tick.valid && tick.ready) |=> (state_reg == ST_MSL))
        else $error("accepted tick did not start the sequence");

    // a new result appears only out of the commit state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == ST_UPD))
        else $error("result valid rose outside commit");

    // digit counter never runs past the operand width
    a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        is_mul |-> (dig_reg <= ndig_m1))
        else $error("digit counter out of range");

    // heading moves only on commit
    a_heading_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(heading_reg) |-> $past(commit))
        else $error("heading changed without commit");
`endif

endmodule
